### design/point_in_rotated_ellipse_core_macros.svh
// Assertion macros used by the checker file of the ellipse hit-test core.
`ifndef POINT_IN_ROTATED_ELLIPSE_CORE_MACROS_SVH
`define POINT_IN_ROTATED_ELLIPSE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PIRE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ellipse core check failed");

// Implication with a delay set by the argument n.
`define PIRE_ASSERT_DELAY(lbl, ante, n, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##n (cons)) \
    else $error("ellipse core delayed check failed");

`endif

### design/pire_pkg.sv
// Package: widths, constants and payload types of the ellipse hit-test core.
package pire_pkg;

  localparam int COORD_BITS = 16;
  localparam int ANGLE_BITS = 16;

  // angle fraction to Q15 argument
  localparam int unsigned ANG_SHL = (ANGLE_BITS <= 17) ? (17 - ANGLE_BITS) : 0;
  localparam int unsigned ANG_SHR = (ANGLE_BITS > 17) ? (ANGLE_BITS - 17) : 0;

  // quarter-sine polynomial coefficients, Q15
  localparam logic [15:0] SIN_A = 16'd51472;
  localparam logic [14:0] SIN_B = 15'd21024;
  localparam logic [11:0] SIN_C = 12'd2320;
  localparam logic [14:0] RND_HALF = 15'd16384;
  localparam logic [14:0] TRIG_MAX = 15'h7fff;
  localparam logic [16:0] QUARTER_ONE = 17'd32768;

  localparam int QSIN_LAT = 4;
  localparam int LATENCY  = QSIN_LAT + 5;

  localparam int DIF_W = COORD_BITS + 1;   // p - c
  localparam int SC_W  = 17;               // signed sine / cosine
  localparam int PRD_W = DIF_W + SC_W;     // Q19 product
  localparam int SUM_W = PRD_W + 1;        // dot product
  localparam int D0_W  = SUM_W - 15;       // rounded to Q4
  localparam int F1_W  = D0_W + 2;         // 2*D1 + a2
  localparam int MUL_W = 2 * COORD_BITS;
  localparam int SQ_W  = 4 * COORD_BITS;

  typedef enum logic [1:0] {
    QUAD0 = 2'd0,
    QUAD1 = 2'd1,
    QUAD2 = 2'd2,
    QUAD3 = 2'd3
  } quad_e;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic        [ANGLE_BITS-1:0] angle;
    logic        [COORD_BITS-1:0] axis_along;
    logic        [COORD_BITS-1:0] width_across;
  } pire_in_t;

  typedef struct packed {
    logic inside_res;
    logic bad_axis;
  } pire_res_t;

endpackage

### design/pire_qsin.sv
// Four-stage quarter-wave sine, Q15 argument in [0,1], Q15 result clamped.
module pire_qsin (
  input  logic        clk_i,
  input  logic [15:0] x_i,
  output logic [14:0] s_o
);
  import pire_pkg::*;

  logic [15:0] x_a_q, x2_a_q, x2_d;
  logic [15:0] x_b_q, x2_b_q;
  logic [14:0] u_b_q, u_d;
  logic [15:0] x_c_q, w_c_q, w_d;
  logic [14:0] s_q, s_d;
  logic [31:0] prod_a;
  logic [27:0] prod_b;
  logic [30:0] prod_c;
  logic [31:0] prod_d;

  // x^2
  always_comb begin
    prod_a = {16'b0, x_i} * {16'b0, x_i} + 32'(RND_HALF);
    x2_d   = prod_a[30:15];
  end

  // u = B - C*x^2
  always_comb begin
    prod_b = 28'(SIN_C) * 28'(x2_a_q) + 28'(RND_HALF);
    u_d    = SIN_B - prod_b[29-2:15];
  end

  // w = A - u*x^2
  always_comb begin
    prod_c = 31'(u_b_q) * 31'(x2_b_q) + 31'(RND_HALF);
    w_d    = SIN_A - prod_c[30:15];
  end

  // s = w*x, clamped
  always_comb begin
    prod_d = 32'(w_c_q) * 32'(x_c_q) + 32'(RND_HALF);
    s_d    = (prod_d[31:15] > 17'(TRIG_MAX)) ? TRIG_MAX : prod_d[29:15];
  end

  always_ff @(posedge clk_i) begin
    x_a_q  <= x_i;
    x2_a_q <= x2_d;
    x_b_q  <= x_a_q;
    x2_b_q <= x2_a_q;
    u_b_q  <= u_d;
    x_c_q  <= x_b_q;
    w_c_q  <= w_d;
    s_q    <= s_d;
  end

  assign s_o = s_q;

endmodule

### design/point_in_rotated_ellipse_core.sv
// Top level: pipelined fixed-point test of a point against a rotated segment ellipse.
//
// Usage
//   Input transfer: item_i is taken at a rising edge where start is high and
//   busy is low. busy is always low, so a new point/ellipse pair may be
//   offered in every cycle.
//   Result transfer: done_o is high for exactly one cycle, carrying result_o
//   (inside_res, bad_axis). Results come out in the order items went in.
//   Throughput: one item per cycle.
//   Pipeline: 4 stages of quarter-sine polynomial (one multiply each), then
//   rotation products, dot-product sum and rounding, axis scaling, squaring,
//   and the final sum/compare into the output register.
//   Reset: rst_ni low clears all valid bits; nothing in flight survives.
//   The receiver cannot stall: each result is shown once and then replaced.
//   A zero axis gives bad_axis=1 and inside_res=0.
module point_in_rotated_ellipse_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  pire_pkg::pire_in_t item_i,
  output logic               done_o,
  output pire_pkg::pire_res_t result_o
);
  import pire_pkg::*;

  typedef struct packed {
    logic signed [DIF_W-1:0]      dx;
    logic signed [DIF_W-1:0]      dy;
    logic        [COORD_BITS-1:0] a1;
    logic        [COORD_BITS-1:0] a2;
    logic                         bad;
    quad_e                        quad;
  } side_t;

  typedef struct packed {
    logic signed [PRD_W-1:0]      p00;
    logic signed [PRD_W-1:0]      p01;
    logic signed [PRD_W-1:0]      p10;
    logic signed [PRD_W-1:0]      p11;
    logic        [COORD_BITS-1:0] a1;
    logic        [COORD_BITS-1:0] a2;
    logic                         bad;
  } rot_t;

  typedef struct packed {
    logic signed [D0_W-1:0]       d0;
    logic signed [F1_W-1:0]       f1;
    logic        [COORD_BITS-1:0] a1;
    logic        [COORD_BITS-1:0] a2;
    logic                         bad;
  } prj_t;

  typedef struct packed {
    logic [MUL_W-1:0] x;
    logic [MUL_W-1:0] y;
    logic [MUL_W-1:0] z;
    logic             skip;
  } scl_t;

  typedef struct packed {
    logic [SQ_W-1:0] xx;
    logic [SQ_W-1:0] yy;
    logic [SQ_W-1:0] zz;
    logic            skip;
  } sqr_t;

  logic                  accept;
  logic [LATENCY-1:0]    vld_q;
  logic [ANGLE_BITS-3:0] frac;
  logic [15:0]           xs, xc;
  logic [14:0]           sq, cq;
  side_t                 side_d;
  side_t                 side_q [QSIN_LAT];
  rot_t                  rot_d, rot_q;
  prj_t                  prj_d, prj_q;
  scl_t                  scl_d, scl_q;
  sqr_t                  sqr_d, sqr_q;
  pire_res_t             res_d, res_q;

  // Fully pipelined: never refuses a transfer.
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // Front end: sine/cosine arguments and offsets.
  always_comb begin
    frac        = item_i.angle[ANGLE_BITS-3:0];
    xs          = 16'((32'(frac) << ANG_SHL) >> ANG_SHR);
    xc          = 16'(QUARTER_ONE - 17'(xs));
    side_d.dx   = DIF_W'(item_i.point_x) - DIF_W'(item_i.center_x);
    side_d.dy   = DIF_W'(item_i.point_y) - DIF_W'(item_i.center_y);
    side_d.a1   = item_i.axis_along;
    side_d.a2   = item_i.width_across;
    side_d.bad  = (item_i.axis_along == '0) || (item_i.width_across == '0);
    side_d.quad = quad_e'(item_i.angle[ANGLE_BITS-1:ANGLE_BITS-2]);
  end

  pire_qsin u_sin (
    .clk_i (clk_i),
    .x_i   (xs),
    .s_o   (sq)
  );

  pire_qsin u_cos (
    .clk_i (clk_i),
    .x_i   (xc),
    .s_o   (cq)
  );

  always_ff @(posedge clk_i) begin
    side_q[0] <= side_d;
    for (int i = 1; i < QSIN_LAT; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  // Quadrant fold and rotation products.
  always_comb begin
    logic signed [SC_W-1:0] sqs, cqs, sn, cs;
    side_t sd;
    sd  = side_q[QSIN_LAT-1];
    sqs = $signed({2'b00, sq});
    cqs = $signed({2'b00, cq});
    case (sd.quad)
      QUAD0:   begin sn = sqs;  cs = cqs;  end
      QUAD1:   begin sn = cqs;  cs = -sqs; end
      QUAD2:   begin sn = -sqs; cs = -cqs; end
      default: begin sn = -cqs; cs = sqs;  end
    endcase
    rot_d.p00 = PRD_W'(cs) * PRD_W'(sd.dx);
    rot_d.p01 = PRD_W'(sn) * PRD_W'(sd.dy);
    rot_d.p10 = PRD_W'(cs) * PRD_W'(sd.dy);
    rot_d.p11 = PRD_W'(sn) * PRD_W'(sd.dx);
    rot_d.a1  = sd.a1;
    rot_d.a2  = sd.a2;
    rot_d.bad = sd.bad;
  end

  // Dot products, round Q19 -> Q4 (ties up), shift by half width.
  always_comb begin
    logic signed [SUM_W-1:0] e0, e1;
    logic signed [D0_W-1:0]  r1;
    e0        = SUM_W'(rot_q.p00) + SUM_W'(rot_q.p01) + SUM_W'(RND_HALF);
    e1        = SUM_W'(rot_q.p10) - SUM_W'(rot_q.p11) + SUM_W'(RND_HALF);
    prj_d.d0  = e0[SUM_W-1:15];
    r1        = e1[SUM_W-1:15];
    prj_d.f1  = (F1_W'(r1) <<< 1) + $signed(F1_W'(rot_q.a2));
    prj_d.a1  = rot_q.a1;
    prj_d.a2  = rot_q.a2;
    prj_d.bad = rot_q.bad;
  end

  // Far check and axis scaling.
  always_comb begin
    logic [D0_W-1:0] m0;
    logic [F1_W-1:0] m1;
    m0 = prj_q.d0[D0_W-1] ? D0_W'(-prj_q.d0) : D0_W'(prj_q.d0);
    m1 = prj_q.f1[F1_W-1] ? F1_W'(-prj_q.f1) : F1_W'(prj_q.f1);
    scl_d.skip = prj_q.bad || (m0 >= D0_W'(prj_q.a1)) || (m1 >= F1_W'(prj_q.a2));
    scl_d.x    = MUL_W'(m0[COORD_BITS-1:0]) * MUL_W'(prj_q.a2);
    scl_d.y    = MUL_W'(m1[COORD_BITS-1:0]) * MUL_W'(prj_q.a1);
    scl_d.z    = MUL_W'(prj_q.a1) * MUL_W'(prj_q.a2);
  end

  // Squares.
  always_comb begin
    sqr_d.xx   = SQ_W'(scl_q.x) * SQ_W'(scl_q.x);
    sqr_d.yy   = SQ_W'(scl_q.y) * SQ_W'(scl_q.y);
    sqr_d.zz   = SQ_W'(scl_q.z) * SQ_W'(scl_q.z);
    sqr_d.skip = scl_q.skip;
  end

  // Final compare: x^2 + y^2 < z^2, exact at full width.
  always_comb begin
    logic [SQ_W:0] tot;
    tot              = (SQ_W+1)'(sqr_q.xx) + (SQ_W+1)'(sqr_q.yy);
    res_d.inside_res = ~sqr_q.skip && (tot < (SQ_W+1)'(sqr_q.zz));
    res_d.bad_axis   = 1'b0;
  end

  // bad flag rides along through the last stages
  logic [LATENCY-QSIN_LAT-2:0] bad_q;

  always_ff @(posedge clk_i) begin
    rot_q <= rot_d;
    prj_q <= prj_d;
    scl_q <= scl_d;
    sqr_q <= sqr_d;
    res_q <= '{inside_res: res_d.inside_res, bad_axis: bad_q[LATENCY-QSIN_LAT-2]};
    bad_q <= {bad_q[LATENCY-QSIN_LAT-3:0], side_q[QSIN_LAT-1].bad};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LATENCY-2:0], accept};
    end
  end

  assign done_o   = vld_q[LATENCY-1];
  assign result_o = res_q;

endmodule

### design/pire_checker.sv
// Port-level checker for the ellipse hit-test core, with its bind.
`include "point_in_rotated_ellipse_core_macros.svh"

module pire_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input pire_pkg::pire_in_t  item_i,
  input logic                done_o,
  input pire_pkg::pire_res_t result_o
);
  import pire_pkg::*;

  `PIRE_ASSERT_IMPL(a_bad_not_inside, done_o, !(result_o.inside_res && result_o.bad_axis))
  `PIRE_ASSERT_IMPL(a_never_busy, 1'b1, !busy)
  `PIRE_ASSERT_IMPL(a_done_has_source, done_o, $past(start && !busy, LATENCY))
  `PIRE_ASSERT_DELAY(a_transfer_done, start && !busy, LATENCY, done_o)
  `PIRE_ASSERT_DELAY(a_zero_axis, start && !busy && (item_i.axis_along == '0 || item_i.width_across == '0), LATENCY, done_o && result_o.bad_axis && !result_o.inside_res)

endmodule

bind point_in_rotated_ellipse_core pire_checker u_pire_checker (.*);
